// ----- design/gne_pkg.sv -----
// Shared types and constants for the gate netlist evaluator.
package gne_pkg;

  // Field widths of the item and result channels
  localparam int FUNC_W     = 2;
  localparam int IDX_W      = 12;
  localparam int RAW_W      = 16;
  localparam int RAW_KIND_W = 8;
  localparam int SEL_W      = 9;

  // Gate kinds: the raw kind is reduced modulo GATE_KINDS
  localparam int GATE_KINDS = 4;
  localparam int KIND_W     = $clog2(GATE_KINDS);

  // Configuration port and register widths
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int IC_REG_W   = 10;
  localparam int OC_REG_W   = 10;
  localparam int NC_REG_W   = 13;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_GATE  = 2'd0,
    FUNC_INPUT = 2'd1,
    FUNC_EVAL  = 2'd2
  } gne_func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INPUT_COUNT  = 2'd0,
    CFG_OUTPUT_COUNT = 2'd1,
    CFG_NODE_COUNT   = 2'd2
  } gne_cfg_idx_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_XOR  = 2'd0,
    KIND_XNOR = 2'd1,
    KIND_AND  = 2'd2,
    KIND_OR   = 2'd3
  } gne_kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REM,
    ST_EVAL,
    ST_RESULT
  } gne_state_t;

endpackage

// ----- design/gne_rem.sv -----
// Bit-serial remainder unit: reduces two raw operand references by one divisor.
module gne_rem #(
  parameter int DIV_W = 13
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [gne_pkg::RAW_W-1:0]  a_raw,
  input  logic [gne_pkg::RAW_W-1:0]  b_raw,
  input  logic [DIV_W-1:0]           divisor,
  output logic                       done,
  output logic [DIV_W-1:0]           rem_a,
  output logic [DIV_W-1:0]           rem_b
);
  import gne_pkg::*;

  localparam int CNT_W = $clog2(RAW_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [RAW_W-1:0] qa;
  logic [RAW_W-1:0] qb;
  logic [DIV_W-1:0] dvsr;
  logic [DIV_W:0]   ta;
  logic [DIV_W:0]   tb;
  logic [DIV_W-1:0] na;
  logic [DIV_W-1:0] nb;

  // One restoring step per lane: shift in next dividend bit, subtract if it fits
  always_comb begin
    ta = {rem_a, qa[RAW_W-1]};
    tb = {rem_b, qb[RAW_W-1]};
    na = (ta >= {1'b0, dvsr}) ? DIV_W'(ta - {1'b0, dvsr}) : ta[DIV_W-1:0];
    nb = (tb >= {1'b0, dvsr}) ? DIV_W'(tb - {1'b0, dvsr}) : tb[DIV_W-1:0];
  end

  // Step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(RAW_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      qa    <= a_raw;
      qb    <= b_raw;
      dvsr  <= divisor;
      rem_a <= '0;
      rem_b <= '0;
    end else if (busy) begin
      qa    <= qa << 1;
      qb    <= qb << 1;
      rem_a <= na;
      rem_b <= nb;
    end
  end

  // Finished remainders are always reduced
  a_rem_reduced: assert property (@(posedge clk) disable iff (rst)
    done |-> (rem_a < dvsr) && (rem_b < dvsr))
    else $error("remainder not below divisor");

  // A new reduction never starts on top of one in flight
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("remainder unit restarted while busy");

endmodule

// ----- design/gate_netlist_evaluator_unit.sv -----
// Top level of the gate netlist evaluator: gate table, value store and sequencer.
//
//  Channel  Signals                                   Direction  Transaction when
//  cfg      cfg_valid/cfg_ready, cfg_index, cfg_data  in         cfg_valid && cfg_ready
//  req      req_valid/req_stall, func .. output_select in        req_valid && !req_stall
//  rsp      rsp_valid/rsp_stall, result_bit, status   out        rsp_valid && !rsp_stall
//
//  After reset a clearing pass zeroes all MAX_INPUTS input bits, with req stalled.
//  Input write and rejected items: IDLE (a valid input bit is written) then RESULT, which loads
//  the output register. Gate write: REM while the remainder unit reduces both operands at once,
//  writing the gate table as it ends, then RESULT. Evaluate: one gate per cycle through gate
//  read, value read and write-back, with the previous gate's result forwarded into the value
//  read. One item at a time; the next is taken while a result waits in rsp, which may stall.
module gate_netlist_evaluator_unit #(
  parameter int MAX_INPUTS = 512,
  parameter int MAX_NODES  = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [gne_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gne_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  logic [gne_pkg::FUNC_W-1:0]      func,
  input  logic [gne_pkg::IDX_W-1:0]       entry_index,
  input  logic [gne_pkg::RAW_W-1:0]       operand_a_raw,
  input  logic [gne_pkg::RAW_W-1:0]       operand_b_raw,
  input  logic [gne_pkg::RAW_KIND_W-1:0]  gate_kind_raw,
  input  logic                            input_value,
  input  logic [gne_pkg::SEL_W-1:0]       output_select,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output logic                            result_bit,
  output logic                            status
);
  import gne_pkg::*;

  localparam int STORE_DEPTH = MAX_INPUTS + MAX_NODES;
  localparam int SA_W        = $clog2(STORE_DEPTH);
  localparam int NI_W        = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int NC_W        = $clog2(MAX_NODES + 1);
  localparam int IC_W        = $clog2(MAX_INPUTS + 1);
  localparam int GT_W        = 2 * SA_W + KIND_W;

  // Storage
  logic [GT_W-1:0] gate_mem  [MAX_NODES];
  logic            value_mem [STORE_DEPTH];

  // Configuration registers
  logic [IC_REG_W-1:0] input_count;
  logic [OC_REG_W-1:0] output_count;
  logic [NC_REG_W-1:0] node_count;
  logic [IC_W-1:0]     ic_eff;
  logic [NC_W-1:0]     nc_eff;

  // Control
  gne_state_t      state;
  gne_state_t      state_next;
  logic [IC_W-1:0] clr_cnt;
  logic            req_accept;
  logic            item_err;
  logic            gate_idx_bad;
  logic            input_idx_bad;
  logic            eval_bad;
  logic            rem_start;
  logic            rem_done;
  logic            eval_start;
  logic            eval_done;
  logic            out_load;
  logic            res_bit;
  logic            res_status;

  // Gate write path
  logic [NI_W-1:0] lat_idx;
  gne_kind_t       lat_kind;
  logic [SA_W-1:0] avail;
  logic [SA_W-1:0] rem_a;
  logic [SA_W-1:0] rem_b;
  logic            gt_we;
  logic [GT_W-1:0] gt_wdata;

  // Value store write port
  logic            vs_we;
  logic [SA_W-1:0] vs_waddr;
  logic            vs_wdata;

  // Evaluation pipeline
  logic            issue_on;
  logic [NI_W-1:0] rd_idx;
  logic [NI_W-1:0] eval_last;
  logic [NI_W-1:0] eval_target;
  logic [GT_W-1:0] gate_q;
  logic            s1_valid;
  logic [NI_W-1:0] s1_idx;
  logic [SA_W-1:0] s1_pa;
  logic [SA_W-1:0] s1_pb;
  gne_kind_t       s1_kind;
  logic            s2_valid;
  logic [NI_W-1:0] s2_idx;
  gne_kind_t       s2_kind;
  logic            va_q;
  logic            vb_q;
  logic            fwd_a;
  logic            fwd_b;
  logic            fwd_val;
  logic            x_bit;
  logic            y_bit;
  logic            gate_out;
  logic [SA_W-1:0] eval_waddr;

  function automatic logic apply_gate(input gne_kind_t kind, input logic x, input logic y);
    logic r;
    unique case (kind)
      KIND_XOR:  r = x ^ y;
      KIND_XNOR: r = ~(x ^ y);
      KIND_AND:  r = x & y;
      KIND_OR:   r = x | y;
      default:   r = 1'b0;
    endcase
    return r;
  endfunction

  // Reduced reference to store address: input bit, or gate region past the inputs
  function automatic logic [SA_W-1:0] resolve(input logic [SA_W-1:0] r,
                                              input logic [IC_W-1:0] ic);
    logic [SA_W-1:0] res;
    if (r < SA_W'(ic)) res = r;
    else               res = SA_W'(MAX_INPUTS) + (r - SA_W'(ic));
    return res;
  endfunction

  assign cfg_ready  = 1'b1;
  assign req_accept = req_valid && !req_stall;

  // Effective counts
  always_comb begin
    if (input_count == '0)                     ic_eff = IC_W'(1);
    else if (32'(input_count) > MAX_INPUTS)    ic_eff = IC_W'(MAX_INPUTS);
    else                                       ic_eff = IC_W'(input_count);
    if (32'(node_count) > MAX_NODES)           nc_eff = NC_W'(MAX_NODES);
    else                                       nc_eff = NC_W'(node_count);
  end

  // Item checks
  always_comb begin
    gate_idx_bad  = 32'(entry_index) >= MAX_NODES;
    input_idx_bad = 32'(entry_index) >= 32'(ic_eff);
    eval_bad      = (32'(output_count) > 32'(nc_eff)) ||
                    (32'(output_select) >= 32'(output_count));
    unique case (func)
      FUNC_GATE:  item_err = gate_idx_bad;
      FUNC_INPUT: item_err = input_idx_bad;
      FUNC_EVAL:  item_err = eval_bad;
      default:    item_err = 1'b1;
    endcase
  end

  assign avail = SA_W'(ic_eff) + SA_W'(entry_index);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      input_count  <= IC_REG_W'(1);
      output_count <= OC_REG_W'(1);
      node_count   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_INPUT_COUNT:  input_count  <= cfg_data[IC_REG_W-1:0];
        CFG_OUTPUT_COUNT: output_count <= cfg_data[OC_REG_W-1:0];
        CFG_NODE_COUNT:   node_count   <= cfg_data[NC_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_cnt == IC_W'(MAX_INPUTS - 1)) state_next = ST_IDLE;
      ST_IDLE: begin
        if (req_valid) begin
          if (item_err) begin
            state_next = ST_RESULT;
          end else begin
            unique case (func)
              FUNC_GATE: state_next = ST_REM;
              FUNC_EVAL: state_next = ST_EVAL;
              default:   state_next = ST_RESULT;
            endcase
          end
        end
      end
      ST_REM:    if (rem_done) state_next = ST_RESULT;
      ST_EVAL:   if (eval_done) state_next = ST_RESULT;
      ST_RESULT: if (!rsp_valid || !rsp_stall) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    req_stall  = 1'b1;
    rem_start  = 1'b0;
    eval_start = 1'b0;
    gt_we      = 1'b0;
    vs_we      = 1'b0;
    vs_waddr   = eval_waddr;
    vs_wdata   = gate_out;
    out_load   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        vs_we    = 1'b1;
        vs_waddr = SA_W'(clr_cnt);
        vs_wdata = 1'b0;
      end
      ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          unique case (func)
            FUNC_GATE:  rem_start = !gate_idx_bad;
            FUNC_INPUT: begin
              vs_we    = !input_idx_bad;
              vs_waddr = SA_W'(entry_index);
              vs_wdata = input_value;
            end
            FUNC_EVAL:  eval_start = !eval_bad;
            default: ;
          endcase
        end
      end
      ST_REM:    gt_we = rem_done;
      ST_EVAL:   vs_we = s2_valid;
      ST_RESULT: out_load = !rsp_valid || !rsp_stall;
      default: ;
    endcase
  end

  // State and clearing counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + IC_W'(1);
    end
  end

  // Item latch and pending result
  always_ff @(posedge clk) begin
    if (req_accept) begin
      lat_idx     <= NI_W'(entry_index);
      lat_kind    <= gne_kind_t'(gate_kind_raw[KIND_W-1:0]);
      eval_last   <= NI_W'(nc_eff - NC_W'(1));
      eval_target <= NI_W'(nc_eff - NC_W'(output_count) + NC_W'(output_select));
      res_bit     <= 1'b0;
      res_status  <= item_err;
    end else if (s2_valid && (s2_idx == eval_target)) begin
      res_bit <= gate_out;
    end
  end

  // Operand reduction
  gne_rem #(
    .DIV_W (SA_W)
  ) u_rem (
    .clk     (clk),
    .rst     (rst),
    .start   (rem_start),
    .a_raw   (operand_a_raw),
    .b_raw   (operand_b_raw),
    .divisor (avail),
    .done    (rem_done),
    .rem_a   (rem_a),
    .rem_b   (rem_b)
  );

  assign gt_wdata = {resolve(rem_a, ic_eff), resolve(rem_b, ic_eff), lat_kind};

  // Gate table: one write port, registered read
  always_ff @(posedge clk) begin
    if (gt_we) gate_mem[lat_idx] <= gt_wdata;
    gate_q <= gate_mem[rd_idx];
  end

  // Value store: one write port, two registered reads
  always_ff @(posedge clk) begin
    if (vs_we) value_mem[vs_waddr] <= vs_wdata;
    va_q <= value_mem[s1_pa];
    vb_q <= value_mem[s1_pb];
  end

  // Stage 1 decode of the gate entry
  assign s1_pa   = gate_q[GT_W-1 -: SA_W];
  assign s1_pb   = gate_q[KIND_W +: SA_W];
  assign s1_kind = gne_kind_t'(gate_q[KIND_W-1:0]);

  // Stage 2 evaluate; previous gate's result bypasses the store read
  assign x_bit      = fwd_a ? fwd_val : va_q;
  assign y_bit      = fwd_b ? fwd_val : vb_q;
  assign gate_out   = apply_gate(s2_kind, x_bit, y_bit);
  assign eval_waddr = SA_W'(MAX_INPUTS) + SA_W'(s2_idx);
  assign eval_done  = s2_valid && (s2_idx == eval_last);

  // Pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_on <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (eval_start)                           issue_on <= 1'b1;
      else if (issue_on && rd_idx == eval_last) issue_on <= 1'b0;
      s1_valid <= issue_on;
      s2_valid <= s1_valid;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    if (eval_start)    rd_idx <= '0;
    else if (issue_on) rd_idx <= rd_idx + NI_W'(1);
    s1_idx  <= rd_idx;
    s2_idx  <= s1_idx;
    s2_kind <= s1_kind;
    fwd_a   <= s2_valid && (s1_pa == eval_waddr);
    fwd_b   <= s2_valid && (s1_pb == eval_waddr);
    fwd_val <= gate_out;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result_bit <= res_bit;
      status     <= res_status;
    end
  end

  // Gates leave the pipeline in strict order, one behind the next
  a_gate_order: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s2_valid) |-> (s1_idx == s2_idx + NI_W'(1)))
    else $error("evaluation pipeline out of order");

  // No gate past the last one is ever written back
  a_gate_bound: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> (s2_idx <= eval_last) && (state == ST_EVAL))
    else $error("gate write-back beyond node count");

  // Remainders only land while a gate write is pending
  a_rem_state: assert property (@(posedge clk) disable iff (rst)
    rem_done |-> (state == ST_REM))
    else $error("remainder result outside gate write");

endmodule

// ----- tb/gne_checker.sv -----
// Channel monitor for the gate netlist evaluator: predicts every result and compares it.
module gne_checker #(
  parameter int MAX_INPUTS = 512,
  parameter int MAX_NODES  = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [gne_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gne_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            req_valid,
  input  logic                            req_stall,
  input  logic [gne_pkg::FUNC_W-1:0]      func,
  input  logic [gne_pkg::IDX_W-1:0]       entry_index,
  input  logic [gne_pkg::RAW_W-1:0]       operand_a_raw,
  input  logic [gne_pkg::RAW_W-1:0]       operand_b_raw,
  input  logic [gne_pkg::RAW_KIND_W-1:0]  gate_kind_raw,
  input  logic                            input_value,
  input  logic [gne_pkg::SEL_W-1:0]       output_select,
  input  logic                            rsp_valid,
  input  logic                            rsp_stall,
  input  logic                            result_bit,
  input  logic                            status,
  output int unsigned                     fail_count,
  output int unsigned                     pending
);
  import gne_pkg::*;

  localparam int STORE_DEPTH = MAX_INPUTS + MAX_NODES;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic result_bit;
    logic status;
  } net_result_t;

  // Register copies and network state
  logic [IC_REG_W-1:0] ic_reg;
  logic [OC_REG_W-1:0] oc_reg;
  logic [NC_REG_W-1:0] nc_reg;
  int unsigned src_a [MAX_NODES];
  int unsigned src_b [MAX_NODES];
  gne_kind_t   kind_tab [MAX_NODES];
  bit          store [STORE_DEPTH];

  net_result_t result_q [$];
  int unsigned fails = 0;

  function automatic int unsigned inputs_in_use();
    if (ic_reg == '0) return 1;
    if (ic_reg > MAX_INPUTS) return MAX_INPUTS;
    return 32'(ic_reg);
  endfunction

  function automatic int unsigned nodes_in_use();
    if (nc_reg > MAX_NODES) return MAX_NODES;
    return 32'(nc_reg);
  endfunction

  // Reduced reference below the input count is an input bit, else a gate slot
  function automatic int unsigned store_addr(int unsigned raw, int unsigned avail,
                                             int unsigned ic);
    int unsigned r;
    r = raw % avail;
    return (r < ic) ? r : MAX_INPUTS + (r - ic);
  endfunction

  function automatic bit gate_out(gne_kind_t k, bit x, bit y);
    case (k)
      KIND_XOR:  return x ^ y;
      KIND_XNOR: return ~(x ^ y);
      KIND_AND:  return x & y;
      default:   return x | y;
    endcase
  endfunction

  // Applies one request to the network copy and returns the result it should give
  function automatic net_result_t net_step(logic [FUNC_W-1:0] f, int unsigned idx,
                                           int unsigned ra, int unsigned rb,
                                           int unsigned rk, bit bv, int unsigned sel);
    net_result_t r;
    int unsigned ic;
    int unsigned nc;
    int unsigned i;
    r  = '0;
    ic = inputs_in_use();
    case (f)
      FUNC_GATE: begin
        if (idx >= MAX_NODES) begin
          r.status = 1'b1;
        end else begin
          src_a[idx]    = store_addr(ra, ic + idx, ic);
          src_b[idx]    = store_addr(rb, ic + idx, ic);
          kind_tab[idx] = gne_kind_t'(rk % GATE_KINDS);
        end
      end
      FUNC_INPUT: begin
        if (idx >= ic) r.status = 1'b1;
        else store[idx] = bv;
      end
      FUNC_EVAL: begin
        nc = nodes_in_use();
        if (oc_reg > nc || sel >= oc_reg) begin
          r.status = 1'b1;
        end else begin
          // gates in index order, each from earlier values
          for (i = 0; i < nc; i++)
            store[MAX_INPUTS + i] = gate_out(kind_tab[i], store[src_a[i]], store[src_b[i]]);
          r.result_bit = store[MAX_INPUTS + nc - oc_reg + sel];
        end
      end
      default: r.status = 1'b1;
    endcase
    return r;
  endfunction

  task automatic note_miss(string what, logic want, logic got);
    fails++;
    if (fails <= REPORT_LIMIT)
      $display("gne_checker: %s mismatch at %0t: expected %b, got %b", what, $time, want, got);
  endtask

  // Register writes, then requests, then responses of this edge
  always @(posedge clk) begin
    net_result_t want;
    int unsigned j;
    if (rst) begin
      ic_reg = IC_REG_W'(1);
      oc_reg = OC_REG_W'(1);
      nc_reg = '0;
      for (j = 0; j < STORE_DEPTH; j++) store[j] = 1'b0;
      for (j = 0; j < MAX_NODES; j++) begin
        src_a[j]    = 0;
        src_b[j]    = 0;
        kind_tab[j] = KIND_XOR;
      end
      result_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_INPUT_COUNT:  ic_reg = cfg_data[IC_REG_W-1:0];
          CFG_OUTPUT_COUNT: oc_reg = cfg_data[OC_REG_W-1:0];
          CFG_NODE_COUNT:   nc_reg = cfg_data[NC_REG_W-1:0];
          default: ;
        endcase
      end
      if (req_valid && !req_stall) begin
        want = net_step(func, 32'(entry_index), 32'(operand_a_raw), 32'(operand_b_raw),
                        32'(gate_kind_raw), input_value, 32'(output_select));
        result_q = {result_q, want};
      end
      if (rsp_valid && !rsp_stall) begin
        if (result_q.size() == 0) begin
          fails++;
          if (fails <= REPORT_LIMIT)
            $display("gne_checker: unexpected transaction at %0t: result_bit %b status %b",
                     $time, result_bit, status);
        end else begin
          want = result_q.pop_front();
          if (result_bit !== want.result_bit) note_miss("result_bit", want.result_bit, result_bit);
          if (status !== want.status) note_miss("status", want.status, status);
        end
      end
    end
    pending    <= result_q.size();
    fail_count <= fails;
  end

endmodule

// ----- tb/tb_top.sv -----
// Testbench top for the gate netlist evaluator: clock, reset, stimulus and verdict.
module tb_top;
  import gne_pkg::*;

  localparam int MAX_INPUTS       = 512;
  localparam int MAX_NODES        = 4096;
  localparam int CYCLE_LIMIT      = 1_000_000;
  localparam int SETTLE_CYCLES    = 50;
  localparam int RANDOM_PER_PHASE = 30;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  req_valid = 1'b0;
  logic                  req_stall;
  logic [FUNC_W-1:0]     func = '0;
  logic [IDX_W-1:0]      entry_index = '0;
  logic [RAW_W-1:0]      operand_a_raw = '0;
  logic [RAW_W-1:0]      operand_b_raw = '0;
  logic [RAW_KIND_W-1:0] gate_kind_raw = '0;
  logic                  input_value = 1'b0;
  logic [SEL_W-1:0]      output_select = '0;
  logic                  rsp_valid;
  logic                  rsp_stall = 1'b0;
  logic                  result_bit;
  logic                  status;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycles = 0;

  // Idle percentages and the settings currently programmed
  int unsigned send_gap_pct = 6;
  int unsigned recv_stall_pct = 79;
  int unsigned ic_eff = 1;
  int unsigned oc_now = 1;
  int unsigned nc_eff = 0;
  bit          gate_set [MAX_NODES];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  gate_netlist_evaluator_unit #(
    .MAX_INPUTS(MAX_INPUTS),
    .MAX_NODES (MAX_NODES)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .func         (func),
    .entry_index  (entry_index),
    .operand_a_raw(operand_a_raw),
    .operand_b_raw(operand_b_raw),
    .gate_kind_raw(gate_kind_raw),
    .input_value  (input_value),
    .output_select(output_select),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .result_bit   (result_bit),
    .status       (status)
  );

  gne_checker #(
    .MAX_INPUTS(MAX_INPUTS),
    .MAX_NODES (MAX_NODES)
  ) u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .func         (func),
    .entry_index  (entry_index),
    .operand_a_raw(operand_a_raw),
    .operand_b_raw(operand_b_raw),
    .gate_kind_raw(gate_kind_raw),
    .input_value  (input_value),
    .output_select(output_select),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .result_bit   (result_bit),
    .status       (status),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  // Response back-pressure
  always @(posedge clk) rsp_stall <= ($urandom_range(99) < recv_stall_pct);

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Register write; cfg_valid stays high across back-to-back writes
  task automatic write_reg(gne_cfg_idx_t idx, int unsigned data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data[CFG_DATA_W-1:0];
    do @(posedge clk); while (cfg_ready !== 1'b1);
  endtask

  task automatic set_counts(int unsigned ic, int unsigned oc, int unsigned nc);
    write_reg(CFG_INPUT_COUNT, ic);
    write_reg(CFG_OUTPUT_COUNT, oc);
    write_reg(CFG_NODE_COUNT, nc);
    cfg_valid <= 1'b0;
    ic_eff = (ic == 0) ? 1 : ((ic > MAX_INPUTS) ? MAX_INPUTS : ic);
    oc_now = oc;
    nc_eff = (nc > MAX_NODES) ? MAX_NODES : nc;
  endtask

  // One request transaction, with a random gap in front of it
  task automatic send(logic [FUNC_W-1:0] f, logic [IDX_W-1:0] idx, logic [RAW_W-1:0] ra,
                      logic [RAW_W-1:0] rb, logic [RAW_KIND_W-1:0] rk, logic bv,
                      logic [SEL_W-1:0] sel);
    while ($urandom_range(99) < send_gap_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid     <= 1'b1;
    func          <= f;
    entry_index   <= idx;
    operand_a_raw <= ra;
    operand_b_raw <= rb;
    gate_kind_raw <= rk;
    input_value   <= bv;
    output_select <= sel;
    do @(posedge clk); while (req_stall !== 1'b0);
    if (f == FUNC_GATE) gate_set[idx] = 1'b1;
  endtask

  task automatic put_gate(logic [IDX_W-1:0] idx, logic [RAW_W-1:0] ra, logic [RAW_W-1:0] rb,
                          logic [RAW_KIND_W-1:0] rk);
    send(FUNC_GATE, idx, ra, rb, rk, 1'($urandom()), SEL_W'($urandom()));
  endtask

  task automatic put_input(logic [IDX_W-1:0] idx, logic bv);
    send(FUNC_INPUT, idx, RAW_W'($urandom()), RAW_W'($urandom()), RAW_KIND_W'($urandom()),
         bv, SEL_W'($urandom()));
  endtask

  task automatic run_eval(logic [SEL_W-1:0] sel);
    send(FUNC_EVAL, IDX_W'($urandom()), RAW_W'($urandom()), RAW_W'($urandom()),
         RAW_KIND_W'($urandom()), 1'($urandom()), sel);
  endtask

  // Wait until every outstanding result has come back
  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Writes every gate below upto that was never written, so evaluation sees no holes
  task automatic fill_gates(int unsigned upto);
    int unsigned i;
    for (i = 0; i < upto; i++)
      if (!gate_set[i])
        put_gate(IDX_W'(i), RAW_W'($urandom()), RAW_W'($urandom()), RAW_KIND_W'($urandom()));
  endtask

  task automatic random_item();
    int unsigned pick;
    logic [SEL_W-1:0] sel;
    pick = $urandom_range(99);
    if (pick < 30) begin
      // gate writes mostly land in or just past the active network
      put_gate(($urandom_range(9) == 0) ? IDX_W'($urandom()) : IDX_W'($urandom_range(nc_eff + 3)),
               ($urandom_range(3) == 0) ? RAW_W'($urandom_range(7)) : RAW_W'($urandom()),
               RAW_W'($urandom()), RAW_KIND_W'($urandom()));
    end else if (pick < 55) begin
      put_input(($urandom_range(6) == 0) ? IDX_W'($urandom())
                                         : IDX_W'($urandom_range(ic_eff - 1)),
                1'($urandom()));
    end else if (pick < 92) begin
      sel = SEL_W'($urandom());
      if (oc_now != 0 && $urandom_range(9) != 0) sel = SEL_W'($urandom_range(oc_now - 1));
      run_eval(sel);
    end else begin
      send(FUNC_UNUSED, IDX_W'($urandom()), RAW_W'($urandom()), RAW_W'($urandom()),
           RAW_KIND_W'($urandom()), 1'($urandom()), SEL_W'($urandom()));
    end
  endtask

  // One setting: program it, complete the gate prefix, then random traffic
  task automatic random_phase(int unsigned gap, int unsigned stall, int unsigned ic,
                              int unsigned oc, int unsigned nc);
    int unsigned n;
    drain();
    send_gap_pct   = gap;
    recv_stall_pct = stall;
    set_counts(ic, oc, nc);
    fill_gates(nc_eff);
    for (n = 0; n < RANDOM_PER_PHASE; n++) begin
      if ($urandom_range(24) == 0) drain();
      random_item();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Four-gate network with operand and kind extremes
    set_counts(4, 2, 4);
    put_gate(12'd0, 16'h0000, 16'hFFFF, 8'h00);
    put_gate(12'd1, 16'hFFFF, 16'h0004, 8'hFF);
    put_gate(12'd2, 16'h8000, 16'h0005, 8'h01);
    put_gate(12'd3, 16'h0006, 16'h7FFF, 8'h02);
    put_input(12'd0, 1'b1);
    put_input(12'd3, 1'b1);
    put_input(12'd4, 1'b1);     // just past the input count
    put_input(12'hFFF, 1'b1);
    run_eval(9'd0);
    run_eval(9'd1);
    run_eval(9'd2);             // select past the output count
    run_eval(9'h1FF);
    send(FUNC_UNUSED, 12'hFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, 9'h1FF);
    put_gate(12'hFFF, 16'hFFFF, 16'hFFFF, 8'hFE);   // top entry of the gate table
    put_input(12'd1, 1'b1);
    put_input(12'd0, 1'b0);
    run_eval(9'd0);
    run_eval(9'd1);

    // No outputs at all
    drain();
    set_counts(4, 0, 4);
    run_eval(9'd0);

    // More outputs than gates
    drain();
    set_counts(4, 5, 4);
    run_eval(9'd0);

    // Input count zero acts as one; empty network
    drain();
    set_counts(0, 1, 0);
    put_input(12'd0, 1'b1);
    put_input(12'd1, 1'b1);
    put_gate(12'd5, 16'h1234, 16'hFEDC, 8'h83);
    run_eval(9'd0);

    // Input count saturates at the store's input size
    drain();
    set_counts(1023, 1, 0);
    put_input(12'd511, 1'b1);
    put_input(12'd512, 1'b1);

    random_phase(6, 79, 6, 3, 12);
    random_phase(79, 6, 1023, 1, 24);
    random_phase(0, 0, 0, 7, 9);

    // Largest counts: node count past the table size, then more outputs than gates
    drain();
    set_counts(1023, 3, 8191);
    run_eval(9'd3);
    run_eval(9'h1FF);
    drain();
    set_counts(1023, 1023, 1000);
    run_eval(9'd0);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/gne_pkg.sv
design/gne_rem.sv
design/gate_netlist_evaluator_unit.sv
tb/gne_checker.sv
tb/tb_top.sv
